/* hdl/bb3_pkg.sv */
// shared constants, types and the reciprocal table for the 3x3 box blur
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CNT_W      = COL_W + 2;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // pixel layout: red in the low byte, alpha in the high byte
    localparam int CHANNELS = 4;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = CHANNELS * CHAN_W;

    // configuration registers
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // arithmetic: nine bytes summed, divided by reciprocal multiply
    localparam int SUM_W       = 12;
    localparam int COUNT_W     = 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // request moving from the control stage into line store and filter
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bottom_ok;
        logic             last;
    } bb3_s1_t;

    // one blurred pixel
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              frame_end;
    } bb3_result_t;

    // ceil(2^RECIP_SHIFT / count), exact floor division for sums up to nine bytes
    function automatic logic [RECIP_W-1:0] bb3_recip(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd2:    r = RECIP_W'((2 ** RECIP_SHIFT + 1) / 2);
            4'd3:    r = RECIP_W'((2 ** RECIP_SHIFT + 2) / 3);
            4'd4:    r = RECIP_W'((2 ** RECIP_SHIFT + 3) / 4);
            4'd5:    r = RECIP_W'((2 ** RECIP_SHIFT + 4) / 5);
            4'd6:    r = RECIP_W'((2 ** RECIP_SHIFT + 5) / 6);
            4'd7:    r = RECIP_W'((2 ** RECIP_SHIFT + 6) / 7);
            4'd8:    r = RECIP_W'((2 ** RECIP_SHIFT + 7) / 8);
            4'd9:    r = RECIP_W'((2 ** RECIP_SHIFT + 8) / 9);
            default: r = RECIP_W'(2 ** RECIP_SHIFT);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/box_blur_3x3_edge_adaptive_unit.sv */
// top level of the 3x3 edge-adaptive box blur over a streamed RGBA raster
// depends on bb3_pkg, bb3_ctrl, bb3_line_store, bb3_filter, bb3_out_queue
//
// usage:
//   pixels enter in row order on the pix channel (valid/ready); operation
//   selects a frame pixel or a flush request that pushes an empty pixel
//   through to drain owed results. results leave on the res channel
//   (valid/ready), one per pixel of the frame, frame_end on the last one.
//   frame_width (index 0) and frame_height (index 1) are written on the cfg
//   channel while the block is idle; a write to either register restarts the stream.
// timing:
//   a result is owed for the pixel one row plus one pixel earlier, so it
//   comes with the request that pushes it out. requests are taken one per
//   cycle while pix_ready is high, a rate set by the line store memory
//   doing one read and one write back per cycle, with forwarding for
//   back-to-back requests to the same column.
// reset and stall:
//   reset clears positions and counters and loads 640 x 480; the line store
//   needs no clearing. when the receiver stalls, results collect in an
//   8-entry queue and pix_ready drops once queued plus in-flight results
//   fill it; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_edge_adaptive_unit
    import bb3_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pix_valid,
    output logic                       pix_ready,
    input  wire logic                  operation,
    input  wire logic [CHAN_W-1:0]     red_in,
    input  wire logic [CHAN_W-1:0]     green_in,
    input  wire logic [CHAN_W-1:0]     blue_in,
    input  wire logic [CHAN_W-1:0]     alpha_in,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic [CHAN_W-1:0]          red_out,
    output logic [CHAN_W-1:0]          green_out,
    output logic [CHAN_W-1:0]          blue_out,
    output logic [CHAN_W-1:0]          alpha_out,
    output logic                       frame_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PIX_W-1:0]  pixel;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    bb3_s1_t           s1;
    logic [PIX_W-1:0]  above1;
    logic [PIX_W-1:0]  above2;
    logic              filt_valid;
    bb3_result_t       filt_res;
    logic [1:0]        filt_pend;
    logic [QCNT_W-1:0] q_count;
    bb3_result_t       q_res;

    assign pixel = {alpha_in, blue_in, green_in, red_in};

    // stream control
    bb3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .operation (operation),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .filt_pend (filt_pend),
        .q_count   (q_count),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1        (s1)
    );

    // line stores
    bb3_line_store u_line_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .s1      (s1),
        .above1  (above1),
        .above2  (above2)
    );

    // window and mean
    bb3_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1),
        .above1    (above1),
        .above2    (above2),
        .res_valid (filt_valid),
        .res       (filt_res),
        .pend      (filt_pend)
    );

    // result queue
    bb3_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (filt_valid),
        .wr_data  (filt_res),
        .rd_valid (res_valid),
        .rd_ready (res_ready),
        .rd_data  (q_res),
        .count    (q_count)
    );

    assign red_out   = q_res.red;
    assign green_out = q_res.green;
    assign blue_out  = q_res.blue;
    assign alpha_out = q_res.alpha;
    assign frame_end = q_res.frame_end;

endmodule

`default_nettype wire

/* hdl/bb3_ctrl.sv */
// stream control: registers, positions, lag and owed-result counts, handshake
// depends on bb3_pkg; feeds the line store and the filter through bb3_s1_t
`timescale 1ns / 1ps
`default_nettype none

module bb3_ctrl
    import bb3_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pix_valid,
    output logic                       pix_ready,
    input  wire logic                  operation,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]            filt_pend,
    input  wire logic [QCNT_W-1:0]     q_count,
    output logic                       rd_en,
    output logic [COL_W-1:0]           rd_addr,
    output bb3_s1_t                    s1
);

    logic [FW_W-1:0]  fw_reg, fw_next;
    logic [FH_W-1:0]  fh_reg, fh_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [CNT_W-1:0] lag_reg, lag_next;
    logic [CNT_W-1:0] tail_reg, tail_next;
    bb3_s1_t          s1_reg, s1_next;

    logic [CNT_W-1:0]  w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [QCNT_W+1:0] busy;
    logic              cfg_acc;
    logic              accept;
    logic              flush;
    logic              take;
    logic              emit;
    logic              in_col_last;
    logic              in_row_last;
    logic              out_col_last;
    logic              out_row_last;
    logic [CNT_W-1:0]  tail_upd;
    logic              restart;

    // effective frame size, out-of-range values clamped
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = CNT_W'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            w_eff = CNT_W'(MAX_WIDTH);
        else
            w_eff = CNT_W'(fw_reg);

        if (fh_reg == '0)
            h_eff = FH_W'(1);
        else if (fh_reg > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
    end

    // credit check against results in flight and queued
    assign busy = (QCNT_W+2)'(s1_reg.valid && s1_reg.emit) + (QCNT_W+2)'(filt_pend)
                + (QCNT_W+2)'(q_count);
    assign cfg_ready = !s1_reg.valid && (filt_pend == 2'd0);

    assign cfg_acc = cfg_valid && cfg_ready;
    // a register write takes the cycle, pixel requests wait for it
    assign pix_ready = (busy < (QCNT_W+2)'(QUEUE_DEPTH)) && !cfg_acc;
    assign accept  = pix_valid && pix_ready;
    assign flush   = (operation == OP_FLUSH);
    assign take    = accept && !(flush && (tail_reg == '0));
    assign emit    = lag_reg >= (w_eff + CNT_W'(1));

    // position wrap flags
    assign in_col_last  = (CNT_W'(in_col_reg) + CNT_W'(1)) >= w_eff;
    assign in_row_last  = (FH_W'(in_row_reg) + FH_W'(1)) >= h_eff;
    assign out_col_last = (CNT_W'(out_col_reg) + CNT_W'(1)) >= w_eff;
    assign out_row_last = (FH_W'(out_row_reg) + FH_W'(1)) >= h_eff;

    assign tail_upd = tail_reg + CNT_W'(!flush) - CNT_W'(emit);

    // next state of positions and counters
    always_comb
    begin
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lag_next     = lag_reg;
        tail_next    = tail_reg;
        s1_next      = '0;
        restart      = 1'b0;

        if (cfg_acc)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    fw_next = cfg_data[FW_W-1:0];
                    restart = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    fh_next = cfg_data[FH_W-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        else if (take)
        begin
            // request for line store update and window shift
            s1_next.valid     = 1'b1;
            s1_next.emit      = emit;
            s1_next.col       = in_col_reg;
            s1_next.pix       = flush ? '0 : pixel;
            s1_next.left_ok   = (out_col_reg != '0);
            s1_next.right_ok  = !out_col_last;
            s1_next.top_ok    = (out_row_reg != '0);
            s1_next.bottom_ok = !out_row_last;
            s1_next.last      = out_col_last && out_row_last;

            // input position
            if (in_col_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_last ? '0 : in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            // lag saturates once results start
            lag_next  = emit ? lag_reg : lag_reg + CNT_W'(1);
            tail_next = tail_upd;

            // output position
            if (emit)
            begin
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_last ? '0 : out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end

            // last owed result drained
            if (flush && (tail_upd == '0))
                restart = 1'b1;
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lag_next     = '0;
            tail_next    = '0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= FRAME_WIDTH_RESET;
            fh_reg      <= FRAME_HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
            tail_reg    <= '0;
            s1_reg      <= '0;
        end
        else
        begin
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lag_reg     <= lag_next;
            tail_reg    <= tail_next;
            s1_reg      <= s1_next;
        end
    end

    assign rd_en   = take;
    assign rd_addr = in_col_reg;
    assign s1      = s1_reg;

    // lag never runs past one row plus one pixel
    a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lag_reg <= (w_eff + CNT_W'(1)))
        else $error("lag count beyond one row plus one pixel");

    // owed results bounded by the pipeline depth of one row plus one
    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= CNT_W'(MAX_WIDTH + 1))
        else $error("owed result count out of range");

endmodule

`default_nettype wire

/* hdl/bb3_line_store.sv */
// two line stores packed in one synchronous memory, read-modify-write per column
// depends on bb3_pkg; read issued by bb3_ctrl, written back in the following cycle
`timescale 1ns / 1ps
`default_nettype none

module bb3_line_store
    import bb3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [COL_W-1:0] rd_addr,
    input  wire bb3_s1_t          s1,
    output logic [PIX_W-1:0]      above1,
    output logic [PIX_W-1:0]      above2
);

    // entry: upper half the row just above, lower half the row two above
    logic [2*PIX_W-1:0] row_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] wb_data;

    // shift the column down by one row
    assign wb_data = {s1.pix, rd_reg[2*PIX_W-1:PIX_W]};

    // write back
    always_ff @(posedge clk)
    begin
        if (s1.valid)
            row_mem[s1.col] <= wb_data;
    end

    // read with forwarding when the same column is written back this cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (s1.valid && (s1.col == rd_addr))
                rd_reg <= wb_data;
            else
                rd_reg <= row_mem[rd_addr];
        end
    end

    assign above1 = rd_reg[2*PIX_W-1:PIX_W];
    assign above2 = rd_reg[PIX_W-1:0];

endmodule

`default_nettype wire

/* hdl/bb3_filter.sv */
// 3x3 window, masked channel sums and reciprocal-multiply mean
// depends on bb3_pkg; takes the column from bb3_line_store
`timescale 1ns / 1ps
`default_nettype none

module bb3_filter
    import bb3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bb3_s1_t          s1,
    input  wire logic [PIX_W-1:0] above1,
    input  wire logic [PIX_W-1:0] above2,
    output logic                  res_valid,
    output bb3_result_t           res,
    output logic [1:0]            pend
);

    // window keeps the two most recent columns, rows top to bottom
    logic [PIX_W-1:0] win_reg [3][2];
    logic [PIX_W-1:0] new_col [3];
    logic [PIX_W-1:0] nb [3][3];
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [1:0]       rows_used;
    logic [1:0]       cols_used;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0] sum_next [3];

    logic               s2_valid_reg;
    logic [SUM_W-1:0]   sum_reg [3];
    logic [RECIP_W-1:0] recip_reg;
    logic [CHAN_W-1:0]  alpha2_reg;
    logic               last2_reg;

    logic               s3_valid_reg;
    logic [PROD_W-1:0]  prod_reg [3];
    logic [CHAN_W-1:0]  alpha3_reg;
    logic               last3_reg;

    assign new_col[0] = above2;
    assign new_col[1] = above1;
    assign new_col[2] = s1.pix;

    // neighborhood: left and centre from the window, right is the new column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            nb[r][0] = win_reg[r][0];
            nb[r][1] = win_reg[r][1];
            nb[r][2] = new_col[r];
        end
    end

    assign row_ok = {s1.bottom_ok, 1'b1, s1.top_ok};
    assign col_ok = {s1.right_ok, 1'b1, s1.left_ok};

    // masked sums of red, green and blue
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (row_ok[r] && col_ok[c])
                        sum_next[k] = sum_next[k] + SUM_W'(nb[r][c][k*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    // number of pixels inside the frame
    assign rows_used = 2'd1 + 2'(s1.top_ok) + 2'(s1.bottom_ok);
    assign cols_used = 2'd1 + 2'(s1.left_ok) + 2'(s1.right_ok);
    assign count     = COUNT_W'(rows_used) * COUNT_W'(cols_used);

    // window shift
    always_ff @(posedge clk)
    begin
        if (s1.valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= new_col[r];
            end
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1.valid && s1.emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // sum stage
    always_ff @(posedge clk)
    begin
        if (s1.valid && s1.emit)
        begin
            for (int k = 0; k < 3; k++)
                sum_reg[k] <= sum_next[k];
            recip_reg  <= bb3_recip(count);
            alpha2_reg <= nb[1][1][3*CHAN_W +: CHAN_W];
            last2_reg  <= s1.last;
        end
    end

    // reciprocal multiply stage
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= PROD_W'(sum_reg[k]) * PROD_W'(recip_reg);
            alpha3_reg <= alpha2_reg;
            last3_reg  <= last2_reg;
        end
    end

    // floor of the mean sits above the fraction bits
    assign res_valid     = s3_valid_reg;
    assign res.red       = prod_reg[0][RECIP_SHIFT +: CHAN_W];
    assign res.green     = prod_reg[1][RECIP_SHIFT +: CHAN_W];
    assign res.blue      = prod_reg[2][RECIP_SHIFT +: CHAN_W];
    assign res.alpha     = alpha3_reg;
    assign res.frame_end = last3_reg;

    assign pend = 2'(s2_valid_reg) + 2'(s3_valid_reg);

endmodule

`default_nettype wire

/* hdl/bb3_out_queue.sv */
// result queue decoupling the filter pipeline from the receiver
// depends on bb3_pkg; occupancy goes back to bb3_ctrl for credit
`timescale 1ns / 1ps
`default_nettype none

module bb3_out_queue
    import bb3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire bb3_result_t wr_data,
    output logic             rd_valid,
    input  wire logic        rd_ready,
    output bb3_result_t      rd_data,
    output logic [QCNT_W-1:0] count
);

    bb3_result_t        q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               rd_en;

    assign rd_valid = (count_reg != '0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = q_mem[rd_ptr_reg];
    assign count    = count_reg;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        count_next = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wr_ptr_reg] <= wr_data;
    end

    // credit scheme must keep a free slot for every result in flight
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("result written into a full queue");

    // occupancy holds when nothing is written or read
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!wr_en && !rd_en) |=> $stable(count_reg))
        else $error("queue occupancy changed without a request");

endmodule

`default_nettype wire
